/* rtl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types and constants for the http chunked body deframer
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int LENGTH_BITS = 48;
    localparam int CHUNK_BITS  = 31;
    localparam int CFG_BITS    = LENGTH_BITS;
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = ((8 + CHUNK_BITS + 3 + 7) / 8) * 8;
    localparam int OUT_USER_BITS = 2;

    // operation codes carried in tuser
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // body modes
    localparam logic [1:0] MODE_CHUNKED = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_CLOSE   = 2'd2;

    // configuration register indexes
    localparam logic CFG_BODY_MODE = 1'b0;
    localparam logic CFG_BODY_LEN  = 1'b1;

    // sticky status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
    localparam logic [2:0] ST_OVERFLOW    = 3'd2;
    localparam logic [2:0] ST_AFTER_END   = 3'd3;
    localparam logic [2:0] ST_CLOSED_EARLY = 3'd4;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [6:0] {
        PH_SIZE_FIRST = 7'b0000001,
        PH_SIZE_MORE  = 7'b0000010,
        PH_SIZE_LF    = 7'b0000100,
        PH_DATA       = 7'b0001000,
        PH_SKIP1      = 7'b0010000,
        PH_SKIP2      = 7'b0100000,
        PH_DONE       = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        t_phase                  phase;
        logic [CHUNK_BITS-1:0]   chunk_rem;
        logic                    last_seen;
        logic [LENGTH_BITS-1:0]  body_count;
        logic [2:0]              err;
    } t_state;

    typedef struct packed {
        logic                  payload_valid;
        logic [7:0]            payload_byte;
        logic                  chunk_start;
        logic [CHUNK_BITS-1:0] chunk_length;
        logic                  body_end;
        logic [2:0]            status;
    } t_result;

endpackage

/* rtl/hcbd_in_stage.sv */
// ----------------------------------------------------------------------------
// hcbd_in_stage
// input holding register, takes a word whenever it is empty or being drained
// ----------------------------------------------------------------------------
module hcbd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  hcbd_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_valid,
    output hcbd_pkg::t_item o_item
);
    import hcbd_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_s_tready = !r_valid || i_take;
    assign n_valid    = (i_s_tvalid && o_s_tready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/hcbd_step.sv */
// ----------------------------------------------------------------------------
// hcbd_step
// next-state and result logic for one word
// ----------------------------------------------------------------------------
module hcbd_step (
    input  hcbd_pkg::t_item                     i_item,
    input  hcbd_pkg::t_state                    i_state,
    input  logic [1:0]                          i_mode,
    input  logic [hcbd_pkg::LENGTH_BITS-1:0]    i_clen,
    output hcbd_pkg::t_state                    o_state,
    output hcbd_pkg::t_result                   o_result
);
    import hcbd_pkg::*;

    t_state                 n_st;
    t_result                res;
    logic                   is_hex;
    logic [3:0]             hex_val;
    logic [CHUNK_BITS-1:0]  size_base;
    logic [CHUNK_BITS-1:0]  rem_dec;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [7:0]             b;

    assign b = i_item.data_byte;

    // hex digit decode
    always_comb begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_val = 4'(b - 8'h37);
        end else begin
            is_hex = 1'b0;
        end
    end

    assign size_base = (i_state.phase == PH_SIZE_FIRST) ? '0 : i_state.chunk_rem;
    assign rem_dec   = (i_state.chunk_rem != '0) ? i_state.chunk_rem - CHUNK_BITS'(1)
                                                 : i_state.chunk_rem;
    assign cnt_inc   = (i_state.body_count == '1) ? i_state.body_count
                                                  : i_state.body_count + LENGTH_BITS'(1);

    always_comb begin
        n_st = i_state;
        res  = '0;
        case (i_item.op)
            OP_START: begin
                n_st.phase      = PH_SIZE_FIRST;
                n_st.chunk_rem  = '0;
                n_st.last_seen  = 1'b0;
                n_st.body_count = '0;
                n_st.err        = ST_OK;
                if (i_mode == MODE_LENGTH && i_clen == '0) begin
                    n_st.phase   = PH_DONE;
                    res.body_end = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (i_state.err == ST_OK && i_state.phase != PH_DONE) begin
                    if (i_mode == MODE_CHUNKED || i_mode == MODE_LENGTH) begin
                        n_st.err = ST_CLOSED_EARLY;
                    end else begin
                        n_st.phase   = PH_DONE;
                        res.body_end = 1'b1;
                    end
                end
            end
            OP_BYTE: begin
                if (i_state.err == ST_OK) begin
                    if (i_state.phase == PH_DONE) begin
                        n_st.err = ST_AFTER_END;
                    end else if (i_mode == MODE_LENGTH) begin
                        if (i_state.body_count >= i_clen) begin
                            n_st.err = ST_AFTER_END;
                        end else begin
                            res.payload_valid = 1'b1;
                            res.payload_byte  = b;
                            n_st.body_count   = cnt_inc;
                            if (cnt_inc >= i_clen) begin
                                n_st.phase   = PH_DONE;
                                res.body_end = 1'b1;
                            end
                        end
                    end else if (i_mode != MODE_CHUNKED) begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = b;
                        n_st.body_count   = cnt_inc;
                    end else begin
                        case (i_state.phase)
                            PH_SIZE_FIRST, PH_SIZE_MORE: begin
                                if (is_hex) begin
                                    if (size_base[CHUNK_BITS-1 -: 4] != 4'd0) begin
                                        n_st.err = ST_OVERFLOW;
                                    end else begin
                                        n_st.chunk_rem = {size_base[CHUNK_BITS-5:0], hex_val};
                                        n_st.phase     = PH_SIZE_MORE;
                                    end
                                end else if (i_state.phase == PH_SIZE_MORE && b == CHAR_CR) begin
                                    n_st.phase = PH_SIZE_LF;
                                end else begin
                                    n_st.err = ST_BAD_HEADER;
                                end
                            end
                            PH_SIZE_LF: begin
                                if (b != CHAR_LF) begin
                                    n_st.err = ST_BAD_HEADER;
                                end else begin
                                    res.chunk_start  = 1'b1;
                                    res.chunk_length = i_state.chunk_rem;
                                    if (i_state.chunk_rem == '0) begin
                                        n_st.last_seen = 1'b1;
                                        n_st.phase     = PH_SKIP1;
                                    end else begin
                                        n_st.phase = PH_DATA;
                                    end
                                end
                            end
                            PH_DATA: begin
                                res.payload_valid = 1'b1;
                                res.payload_byte  = b;
                                n_st.body_count   = cnt_inc;
                                n_st.chunk_rem    = rem_dec;
                                if (rem_dec == '0) begin
                                    n_st.phase = PH_SKIP1;
                                end
                            end
                            PH_SKIP1: begin
                                n_st.phase = PH_SKIP2;
                            end
                            default: begin
                                if (i_state.last_seen) begin
                                    n_st.phase   = PH_DONE;
                                    res.body_end = 1'b1;
                                end else begin
                                    n_st.phase = PH_SIZE_FIRST;
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase
        res.status = n_st.err;
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

/* rtl/http_chunked_body_deframer.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_deframer
// http/1.1 body deframer: chunked, fixed length and close-delimited bodies
// ----------------------------------------------------------------------------
// One word per clock in while the output side is ready, one result word out
// for every word in. A word on the input carries an operation in tuser (byte,
// close, start of body) and the received byte in tdata. An accepted word lands
// in an input register; once the result register is free, the next-state
// logic works on it and writes the result register, so each word passes
// through the input register and then the result register on its way out, and
// the block sustains one word per cycle as long as the output side is ready.
// The end of a body is flagged on tlast. The bounding path is the 48-bit byte
// counter increment and compare against the configured body length.
// Configuration registers are written through a plain write port and are read
// live at every word. Errors are sticky until a start-of-body word.
module http_chunked_body_deframer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [hcbd_pkg::IN_DATA_BITS-1:0]    i_s_tdata,   // data_byte
    input  logic [1:0]                           i_s_tuser,   // op
    // output stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // payload_byte [7:0], chunk_length [38:8], status [41:39], zero fill
    output logic [hcbd_pkg::OUT_DATA_BITS-1:0]   o_m_tdata,
    // payload_valid [0], chunk_start [1]
    output logic [hcbd_pkg::OUT_USER_BITS-1:0]   o_m_tuser,
    output logic                                 o_m_tlast,   // body_end
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_addr,
    input  logic [hcbd_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import hcbd_pkg::*;

    // configuration registers
    logic [1:0]             r_mode;
    logic [LENGTH_BITS-1:0] r_clen;

    // deframer state and result register
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;

    t_item   s_item;
    t_item   q_item;
    logic    q_valid;
    logic    step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CHUNKED;
            r_clen <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BODY_MODE: r_mode <= i_cfg_data[1:0];
                CFG_BODY_LEN:  r_clen <= i_cfg_data[LENGTH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_item.op        = i_s_tuser;
    assign s_item.data_byte = i_s_tdata;

    // result register frees up when empty or when its word is taken
    assign step_go = q_valid && (!r_out_valid || i_m_tready);

    hcbd_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_item     (s_item),
        .i_take     (step_go),
        .o_valid    (q_valid),
        .o_item     (q_item)
    );

    hcbd_step u_step (
        .i_item   (q_item),
        .i_state  (r_state),
        .i_mode   (r_mode),
        .i_clen   (r_clen),
        .o_state  (n_state),
        .o_result (n_res)
    );

    // state advances exactly once per word that moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_SIZE_FIRST;
            r_state.chunk_rem  <= '0;
            r_state.last_seen  <= 1'b0;
            r_state.body_count <= '0;
            r_state.err        <= ST_OK;
            r_out_valid        <= 1'b0;
        end else begin
            if (step_go) begin
                r_state <= n_state;
            end
            r_out_valid <= step_go || (r_out_valid && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'({r_res.status, r_res.chunk_length, r_res.payload_byte});
    assign o_m_tuser  = {r_res.chunk_start, r_res.payload_valid};
    assign o_m_tlast  = r_res.body_end;

`ifndef SYNTH
    // a payload word never carries an error status
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.payload_valid) |-> (r_res.status == ST_OK))
        else $error("payload word with error status");

    // a size line completion carries neither payload nor body end
    a_chunk_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.chunk_start) |-> (!r_res.payload_valid && !r_res.body_end))
        else $error("chunk start mixed with payload or body end");

    // errors stay until a start-of-body word goes through
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.err != ST_OK && !(step_go && q_item.op == OP_START))
        |=> (r_state.err == $past(r_state.err)))
        else $error("sticky error changed without start");

    // in the data phase there is always payload left
    a_data_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DATA) |-> (r_state.chunk_rem != '0))
        else $error("data phase with no bytes remaining");
`endif

endmodule
